// ----- rtl/lz10_pkg.sv -----
`default_nettype none
package lz10_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int SIZE_W       = 24;
  localparam int OUT_DATA_W   = 40;  // out_byte, status, decoded_size, zero pad

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // latch the accepted word
    logic exec;         // decode the latched byte
    logic copy_rd;      // issue the first history read of a back-reference
    logic copy_emit;    // emit one copied byte, prefetch the next
    logic emit_status;  // emit the closing status word, restart the stream
  } lz10_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a word this cycle
    logic lit_pending;  // latched byte is a literal and needs the output
    logic copy_ok;      // latched byte completes a valid back-reference
    logic copy_more;    // more than one copy byte remains
    logic last;         // latched byte closes the stream
  } lz10_sts_t;

endpackage
`default_nettype wire

// ----- rtl/lz10_ctrl.sv -----
`default_nettype none
module lz10_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire lz10_pkg::lz10_sts_t sts,
  output lz10_pkg::lz10_cmd_t    cmd
);
  import lz10_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_COPY_RD = 3'd2;
  localparam logic [2:0] S_COPY_WR = 3'd3;
  localparam logic [2:0] S_STAT    = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // a literal waits for room at the output
        if (!sts.lit_pending || sts.out_free) begin
          cmd.exec = 1'b1;
          if (sts.copy_ok) begin
            state_next = S_COPY_RD;
          end else if (sts.last) begin
            state_next = S_STAT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next  = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (sts.out_free) begin
          cmd.copy_emit = 1'b1;
          if (!sts.copy_more) begin
            state_next = sts.last ? S_STAT : S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lz10_datapath.sv -----
`default_nettype none
module lz10_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lz10_pkg::lz10_cmd_t           cmd,
  output lz10_pkg::lz10_sts_t                sts,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic [lz10_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);
  import lz10_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_FLAGS   = 3'd1;
  localparam logic [2:0] PH_ITEM    = 3'd2;
  localparam logic [2:0] PH_TOKEN2  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_ERR_HDR = 3'd5;
  localparam logic [2:0] PH_ERR_REF = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_REF = 2'd2;
  localparam logic [1:0] ST_EARLY   = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] TYPE_BYTE = 8'h10;
  localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h5A, 8'h37, 8'h37};
  localparam logic [4:0] LEN_BIAS  = 5'd3;

  // decode state
  logic [2:0]        phase, phase_next;
  logic              was_hdr, was_hdr_next;
  logic [3:0]        header_count, header_count_next;
  logic [SIZE_W-1:0] declared_size, declared_size_next;
  logic [SIZE_W-1:0] produced_count, produced_count_next;
  logic [7:0]        flag_bits, flag_bits_next;
  logic [3:0]        flag_bits_left, flag_bits_left_next;
  logic [7:0]        token_high_byte, token_high_byte_next;
  logic [4:0]        copy_left, copy_left_next;
  logic [HIST_AW-1:0] copy_dist, copy_dist_next;

  // latched input word
  logic [7:0] byte_q;
  logic       last_q;

  // history memory
  logic [7:0]         history [WINDOW_DEPTH];
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [7:0]         hist_wdata;
  logic               hist_re;
  logic [HIST_AW-1:0] hist_raddr;
  logic [7:0]         hist_rdata;

  // output register
  logic              out_valid, out_valid_next;
  logic              out_kind, out_kind_next;
  logic [7:0]        out_byte, out_byte_next;
  logic [1:0]        out_status, out_status_next;
  logic [SIZE_W-1:0] out_size, out_size_next;

  logic              out_free;
  logic [4:0]        tok_len;
  logic [12:0]       tok_dist;
  logic              ref_bad;
  logic [SIZE_W-1:0] produced_inc;
  logic [1:0]        status_code;

  function automatic logic [2:0] after_item(input logic [SIZE_W-1:0] prod,
                                            input logic [SIZE_W-1:0] decl,
                                            input logic [3:0]        left);
    logic [2:0] ph;
    if (prod >= decl) begin
      ph = PH_DONE;
    end else if (left == 4'd0) begin
      ph = PH_FLAGS;
    end else begin
      ph = PH_ITEM;
    end
    return ph;
  endfunction

  assign out_free     = !out_valid || m_tready;
  assign produced_inc = produced_count + 24'd1;
  assign tok_len      = {1'b0, token_high_byte[7:4]} + LEN_BIAS;
  assign tok_dist     = {1'b0, token_high_byte[3:0], byte_q} + 13'd1;
  assign ref_bad      = ({11'd0, tok_dist} > produced_count) ||
                        (({1'b0, produced_count} + {20'd0, tok_len}) >
                         {1'b0, declared_size});

  always_comb begin
    if (was_hdr || phase == PH_ERR_HDR) begin
      status_code = ST_BAD_HDR;
    end else if (phase == PH_ERR_REF) begin
      status_code = ST_BAD_REF;
    end else if (phase == PH_DONE) begin
      status_code = ST_OK;
    end else begin
      status_code = ST_EARLY;
    end
  end

  assign sts.out_free    = out_free;
  assign sts.lit_pending = (phase == PH_ITEM) && !flag_bits[7];
  assign sts.copy_ok     = (phase == PH_TOKEN2) && !ref_bad;
  assign sts.copy_more   = copy_left > 5'd1;
  assign sts.last        = last_q;

  always_comb begin
    phase_next           = phase;
    was_hdr_next         = was_hdr;
    header_count_next    = header_count;
    declared_size_next   = declared_size;
    produced_count_next  = produced_count;
    flag_bits_next       = flag_bits;
    flag_bits_left_next  = flag_bits_left;
    token_high_byte_next = token_high_byte;
    copy_left_next       = copy_left;
    copy_dist_next       = copy_dist;
    hist_we              = 1'b0;
    hist_waddr           = produced_count[HIST_AW-1:0];
    hist_wdata           = byte_q;
    hist_re              = 1'b0;
    hist_raddr           = produced_count[HIST_AW-1:0] - copy_dist;
    out_valid_next       = out_valid && !m_tready;
    out_kind_next        = out_kind;
    out_byte_next        = out_byte;
    out_status_next      = out_status;
    out_size_next        = out_size;

    if (cmd.exec) begin
      was_hdr_next = (phase == PH_HEADER);
      case (phase)
        PH_HEADER: begin
          if (header_count < 4'd4) begin
            if (byte_q != MAGIC[header_count[1:0]]) begin
              phase_next = PH_ERR_HDR;
            end
          end else if (header_count == 4'd4) begin
            if (byte_q != TYPE_BYTE) begin
              phase_next = PH_ERR_HDR;
            end
          end else if (header_count == 4'd5) begin
            declared_size_next = declared_size | {16'd0, byte_q};
          end else if (header_count == 4'd6) begin
            declared_size_next = declared_size | {8'd0, byte_q, 8'd0};
          end else if (header_count inside {[4'd7:4'd15]}) begin
            declared_size_next = declared_size | {byte_q, 16'd0};
          end
          header_count_next = header_count + 4'd1;
          if (phase_next == PH_HEADER && header_count_next >= 4'd8) begin
            phase_next = (declared_size_next == '0) ? PH_DONE : PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flag_bits_next      = byte_q;
          flag_bits_left_next = 4'd8;
          phase_next          = PH_ITEM;
        end
        PH_ITEM: begin
          flag_bits_next      = {flag_bits[6:0], 1'b0};
          flag_bits_left_next = flag_bits_left - 4'd1;
          if (flag_bits[7]) begin
            token_high_byte_next = byte_q;
            phase_next           = PH_TOKEN2;
          end else begin
            hist_we             = 1'b1;
            produced_count_next = produced_inc;
            out_valid_next      = 1'b1;
            out_kind_next       = KIND_DATA;
            out_byte_next       = byte_q;
            out_status_next     = ST_OK;
            out_size_next       = '0;
            phase_next = after_item(produced_inc, declared_size,
                                    flag_bits_left - 4'd1);
          end
        end
        PH_TOKEN2: begin
          if (ref_bad) begin
            phase_next = PH_ERR_REF;
          end else begin
            copy_left_next = tok_len;
            copy_dist_next = tok_dist[HIST_AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.copy_rd) begin
      hist_re = 1'b1;
    end

    if (cmd.copy_emit) begin
      hist_we             = 1'b1;
      hist_wdata          = hist_rdata;
      produced_count_next = produced_inc;
      copy_left_next      = copy_left - 5'd1;
      out_valid_next      = 1'b1;
      out_kind_next       = KIND_DATA;
      out_byte_next       = hist_rdata;
      out_status_next     = ST_OK;
      out_size_next       = '0;
      if (copy_left > 5'd1) begin
        // prefetch the next source byte; it may be the one written now
        hist_re    = 1'b1;
        hist_raddr = produced_inc[HIST_AW-1:0] - copy_dist;
      end else begin
        phase_next = after_item(produced_inc, declared_size, flag_bits_left);
      end
    end

    if (cmd.emit_status) begin
      out_valid_next       = 1'b1;
      out_kind_next        = KIND_STATUS;
      out_byte_next        = '0;
      out_status_next      = status_code;
      out_size_next        = (status_code == ST_OK) ? declared_size : '0;
      phase_next           = PH_HEADER;
      was_hdr_next         = 1'b0;
      header_count_next    = '0;
      declared_size_next   = '0;
      produced_count_next  = '0;
      flag_bits_next       = '0;
      flag_bits_left_next  = '0;
      token_high_byte_next = '0;
      copy_left_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      was_hdr         <= 1'b0;
      header_count    <= '0;
      declared_size   <= '0;
      produced_count  <= '0;
      flag_bits       <= '0;
      flag_bits_left  <= '0;
      token_high_byte <= '0;
      copy_left       <= '0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      was_hdr         <= was_hdr_next;
      header_count    <= header_count_next;
      declared_size   <= declared_size_next;
      produced_count  <= produced_count_next;
      flag_bits       <= flag_bits_next;
      flag_bits_left  <= flag_bits_left_next;
      token_high_byte <= token_high_byte_next;
      copy_left       <= copy_left_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_dist  <= copy_dist_next;
    out_kind   <= out_kind_next;
    out_byte   <= out_byte_next;
    out_status <= out_status_next;
    out_size   <= out_size_next;
    if (cmd.load_in) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
  end

  // history: one write port, one registered read port with write-through
  always_ff @(posedge clk) begin
    if (hist_we) begin
      history[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      if (hist_we && hist_waddr == hist_raddr) begin
        hist_rdata <= hist_wdata;
      end else begin
        hist_rdata <= history[hist_raddr];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_kind;
  assign m_tdata  = {{(OUT_DATA_W - SIZE_W - 10){1'b0}}, out_size, out_status, out_byte};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && sts.lit_pending) || cmd.copy_emit || cmd.emit_status |-> out_free)
    else $error("output word overwritten while stalled");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_emit |-> copy_left != 5'd0 && phase == PH_TOKEN2)
    else $error("copy byte emitted with no copy pending");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_status |=> phase == PH_HEADER && produced_count == '0 && header_count == '0)
    else $error("stream state not cleared after status");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    produced_count <= declared_size)
    else $error("decoded more bytes than declared");

endmodule
`default_nettype wire

// ----- rtl/lz77_type10_stream_decompressor_top.sv -----
`default_nettype none
// Path: a literal passes the input latch and then the output register on its way to m_tdata.
// Each input word is accepted, then decoded; a back-reference token adds one history read,
// then one copied byte per cycle while the output has room, for 3 to 18 bytes per token.
// The closing status word is issued after the last input word; output stalls hold back each word.
// Reset: synchronous rst clears the controller, decode state but copy_dist, and output valid;
// the 4 KiB history is not cleared, since it is only read where this stream wrote it.
module lz77_type10_stream_decompressor_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] in_byte
  input  wire logic                          s_tlast,   // in_last
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lz10_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] out_byte, [9:8] status,
                                                        // [33:10] decoded_size, rest zero
  output logic                               m_tuser,   // [0] out_kind
  output logic                               m_tlast    // out_kind, high on the status word
);
  import lz10_pkg::*;

  lz10_cmd_t cmd;
  lz10_sts_t sts;

  // Controller: accepts one word, then sequences decode, history copy and the
  // closing status word; the next word is taken only once this one is done.
  lz10_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: header check, flag shifter, token decode, history memory and the
  // output register that decouples us from a stalled consumer.
  lz10_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- tb/sv/lz77_type10_stream_decompressor_top_tb.sv -----
`timescale 1ns / 1ps
module lz77_type10_stream_decompressor_top_tb;
  import lz10_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BYTES = 290;      // compressed bytes offered after the directed part
  localparam int BIG_STREAM   = 400;      // decoded size of the long stream that takes the stall
  localparam int HOLD_AFTER   = 40;       // input words taken before the long output stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int MIN_MATCH    = 3;
  localparam int MAX_MATCH    = 18;
  localparam bit [31:0] MAGIC_WORD = 32'h3737_5A4C;  // 'L' 'Z' '7' '7', first byte lowest
  localparam bit [7:0]  TYPE_LZ10  = 8'h10;

  typedef enum logic [2:0] {
    DEC_HEADER, DEC_FLAGS, DEC_ITEM, DEC_TOKEN2, DEC_DONE, DEC_BAD_HEADER, DEC_BAD_BACKREF
  } dec_phase_e;

  typedef enum logic [1:0] {ST_OK, ST_BAD_HEADER, ST_BAD_BACKREF, ST_TRUNCATED} dec_status_e;
  typedef enum logic {KIND_DATA, KIND_STATUS} word_kind_e;

  typedef struct packed {
    word_kind_e        kind;
    logic [7:0]        data;
    dec_status_e       status;
    logic [SIZE_W-1:0] decl_size;
    logic              last;
  } out_word_t;

  typedef enum {
    SK_GOOD, SK_PADDED, SK_CUT_SHORT, SK_BAD_HEADER, SK_BAD_BACKREF, SK_RUNT
  } stream_kind_e;

  // Shadow decoder: mirrors the history window and stream state, queues the words owed.
  class lz10_scoreboard;
    bit [7:0]          window [WINDOW_DEPTH];
    bit [3:0]          hdr_idx;
    bit [SIZE_W-1:0]   size_decl;
    bit [SIZE_W-1:0]   produced;
    bit [7:0]          flags;
    bit [3:0]          flags_left;
    bit [7:0]          tok_hi;
    dec_phase_e        phase;
    out_word_t         decoded_words[$];
    int unsigned       mismatches;
    int unsigned       words_seen;
    int unsigned       data_words;
    int unsigned       status_seen[4];

    function new();
      restart();
    endfunction

    // All stream state but the window goes back to its reset value.
    function void restart();
      hdr_idx    = '0;
      size_decl  = '0;
      produced   = '0;
      flags      = '0;
      flags_left = '0;
      tok_hi     = '0;
      phase      = DEC_HEADER;
    endfunction

    function void put_data(bit [7:0] b);
      out_word_t w;
      window[produced[HIST_AW-1:0]] = b;
      produced++;
      w.kind      = KIND_DATA;
      w.data      = b;
      w.status    = ST_OK;
      w.decl_size = '0;
      w.last      = 1'b0;
      decoded_words.push_back(w);
    endfunction

    // Pick the next phase once a literal or a whole copy has gone out.
    function void settle();
      if (produced >= size_decl) phase = DEC_DONE;
      else if (flags_left == 0) phase = DEC_FLAGS;
      else phase = DEC_ITEM;
    endfunction

    function void decode_in_byte(bit [7:0] b, bit last);
      bit          hdr_step;
      bit          is_tok;
      int unsigned len;
      int unsigned offs;
      bit [HIST_AW-1:0] src;
      out_word_t   w;
      hdr_step = (phase == DEC_HEADER);
      case (phase)
        DEC_HEADER: begin
          if (hdr_idx < 4) begin
            if (b != MAGIC_WORD[8*hdr_idx +: 8]) phase = DEC_BAD_HEADER;
          end else if (hdr_idx == 4) begin
            if (b != TYPE_LZ10) phase = DEC_BAD_HEADER;
          end else begin
            size_decl |= SIZE_W'(b) << (8 * (hdr_idx - 5));
          end
          hdr_idx++;
          if (phase == DEC_HEADER && hdr_idx >= 8) phase = (size_decl == 0) ? DEC_DONE : DEC_FLAGS;
        end
        DEC_FLAGS: begin
          flags      = b;
          flags_left = 4'd8;
          phase      = DEC_ITEM;
        end
        DEC_ITEM: begin
          is_tok     = flags[7];
          flags      = flags << 1;
          flags_left = flags_left - 4'd1;
          if (is_tok) begin
            tok_hi = b;
            phase  = DEC_TOKEN2;
          end else begin
            put_data(b);
            settle();
          end
        end
        DEC_TOKEN2: begin
          len  = tok_hi[7:4] + MIN_MATCH;
          offs = {tok_hi[3:0], b} + 1;
          // drop the whole token if it reaches before the stream or past its end
          if (offs > produced || produced + len > size_decl) begin
            phase = DEC_BAD_BACKREF;
          end else begin
            for (int i = 0; i < len; i++) begin
              src = produced[HIST_AW-1:0] - offs[HIST_AW-1:0];
              put_data(window[src]);
            end
            settle();
          end
        end
        default: ;
      endcase
      if (last) begin
        if (hdr_step || phase == DEC_BAD_HEADER) w.status = ST_BAD_HEADER;
        else if (phase == DEC_BAD_BACKREF) w.status = ST_BAD_BACKREF;
        else if (phase == DEC_DONE) w.status = ST_OK;
        else w.status = ST_TRUNCATED;
        w.kind      = KIND_STATUS;
        w.data      = 8'h00;
        w.decl_size = (w.status == ST_OK) ? size_decl : '0;
        w.last      = 1'b1;
        decoded_words.push_back(w);
        restart();
      end
    endfunction

    function void check_out_word(logic [OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
      out_word_t want;
      if (decoded_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: tdata=%h tuser=%b tlast=%b", tdata, tuser, tlast);
        return;
      end
      want = decoded_words.pop_front();
      words_seen++;
      if (want.kind == KIND_STATUS) status_seen[want.status]++;
      else data_words++;
      // tdata: [7:0] out_byte, [9:8] status, [33:10] decoded_size, rest zero
      if (tuser !== want.kind || tdata[7:0] !== want.data || tdata[9:8] !== want.status ||
          tdata[33:10] !== want.decl_size || tdata[OUT_DATA_W-1:34] !== '0 ||
          tlast !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at word %0d: expected kind=%0d byte=%02h status=%0d size=%0d last=%0d",
                   words_seen, want.kind, want.data, want.status, want.decl_size, want.last,
                   " / got kind=%0d byte=%02h status=%0d size=%0d last=%0d pad=%0h",
                   tuser, tdata[7:0], tdata[9:8], tdata[33:10], tlast, tdata[OUT_DATA_W-1:34]);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  lz10_scoreboard sb;
  bit [7:0]       stream_q[$];   // compressed bytes of the stream being sent
  bit             calm;          // no new idle gaps are drawn on either side while set
  bit             rx_hold;       // long output stall in progress
  int             rx_stall;
  int unsigned    in_count;
  int unsigned    streams;
  int unsigned    cycle_count;

  lz77_type10_stream_decompressor_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_header(bit [SIZE_W-1:0] decl);
    for (int i = 0; i < 4; i++) stream_q.push_back(MAGIC_WORD[8*i +: 8]);
    stream_q.push_back(TYPE_LZ10);
    stream_q.push_back(decl[7:0]);
    stream_q.push_back(decl[15:8]);
    stream_q.push_back(decl[23:16]);
  endfunction

  // Build one compressed stream into stream_q. n is the number of bytes the body decodes to.
  function automatic void build_stream(stream_kind_e k, int unsigned n);
    int unsigned decl;
    int unsigned made;
    int unsigned len;
    int unsigned offs;
    int unsigned target;
    int unsigned cut;
    bit [7:0]    flag;
    bit [7:0]    grp[$];
    bit          broke;
    bit          want_tok;
    int          bi;
    stream_q.delete();
    decl = n;
    // declare more than the body gives so the stream can never complete
    if (k == SK_CUT_SHORT) decl = $urandom_range(24'hFF_FFFF, n + 1);
    push_header(SIZE_W'(decl));
    made   = 0;
    broke  = 0;
    offs   = 1;
    target = (n > 0) ? $urandom_range(0, n - 1) : 0;
    while (made < n && !broke) begin
      flag = 8'($urandom);   // bits past the end of the stream stay random
      grp.delete();
      for (bi = 7; bi >= 0 && made < n && !broke; bi--) begin
        want_tok = made >= 1 && n - made >= MIN_MATCH && $urandom_range(0, 1) == 1;
        if (want_tok) len = $urandom_range(MIN_MATCH, (n - made < MAX_MATCH) ? n - made : MAX_MATCH);
        else len = 1;
        if (k == SK_BAD_BACKREF && (made >= target || made + len >= n)) begin
          // break the stream with a copy that overruns the end or reaches before the start
          flag[bi] = 1'b1;
          if (made >= 1 && n - made < MAX_MATCH && $urandom_range(0, 1) == 1) begin
            len  = $urandom_range(MAX_MATCH, (n - made + 1 > MIN_MATCH) ? n - made + 1 : MIN_MATCH);
            offs = $urandom_range(1, made);
          end else begin
            len  = $urandom_range(MIN_MATCH, MAX_MATCH);
            offs = $urandom_range(made + 1, WINDOW_DEPTH);
          end
          broke = 1;
        end else if (want_tok) begin
          flag[bi] = 1'b1;
          // short distances give overlapping copies
          if ($urandom_range(0, 1) == 1) offs = $urandom_range(1, (made < 4) ? made : 4);
          else offs = $urandom_range(1, (made < WINDOW_DEPTH) ? made : WINDOW_DEPTH);
        end else begin
          flag[bi] = 1'b0;
        end
        if (flag[bi]) begin
          grp.push_back({4'(len - MIN_MATCH), 4'((offs - 1) >> 8)});
          grp.push_back(8'(offs - 1));
        end else begin
          grp.push_back(8'($urandom));
        end
        made += len;
      end
      stream_q.push_back(flag);
      foreach (grp[i]) stream_q.push_back(grp[i]);
    end
    case (k)
      SK_PADDED: begin
        repeat ($urandom_range(1, 5)) stream_q.push_back(8'($urandom));
      end
      SK_BAD_BACKREF: begin
        repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom));
      end
      SK_CUT_SHORT: begin
        // end on any byte: a flag, the first half of a token, a literal
        if ($urandom_range(0, 1) == 1) begin
          cut = $urandom_range(9, stream_q.size());
          stream_q = stream_q[0:cut-1];
        end
      end
      SK_BAD_HEADER: begin
        cut = $urandom_range(0, 4);
        stream_q[cut] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) begin
          cut = $urandom_range(cut + 1, stream_q.size());
          stream_q = stream_q[0:cut-1];
        end
      end
      SK_RUNT: begin
        cut = $urandom_range(1, 8);
        stream_q = stream_q[0:cut-1];
        if ($urandom_range(0, 1) == 1) foreach (stream_q[i]) stream_q[i] = 8'($urandom);
      end
      default: ;
    endcase
  endfunction

  // Offer one word at a falling edge; hold it until the rising edge that takes it.
  task automatic send_word(bit [7:0] b, bit last);
    int gap;
    gap = calm ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.decode_in_byte(b, last);
    in_count++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_word(stream_q[i], i == stream_q.size() - 1);
    streams++;
  endtask

  // Output side: random stalls, or none while calm, or the long hold.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) rx_stall = idle_len();
      end
    end
  end

  // Hold the output off for a long stretch inside the long stream; the sender
  // keeps offering, so the block backs up and stops taking input.
  initial begin
    wait (in_count >= HOLD_AFTER);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Check every word taken on the output side.
  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1)
      sb.check_out_word(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               sb.decoded_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned  r;
    int unsigned  n;
    int unsigned  rand_start;
    stream_kind_e k;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Runt stream: last byte inside the header.
    stream_q.delete();
    push_header(24'h000000);
    stream_q = stream_q[0:2];
    send_stream();

    // Zero declared size: done right after the header, trailing byte ignored.
    stream_q.delete();
    push_header(24'h000000);
    stream_q.push_back(8'hFF);
    send_stream();

    // One literal, then the longest copy at distance one: overlapping repeat.
    stream_q.delete();
    push_header(24'd19);
    stream_q.push_back(8'h40);
    stream_q.push_back(8'h5A);
    stream_q.push_back(8'hF0);
    stream_q.push_back(8'h00);
    send_stream();

    // Long well-formed stream first; the output hold lands inside it.
    rand_start = in_count;
    build_stream(SK_GOOD, BIG_STREAM);
    send_stream();

    while (in_count - rand_start < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      r = $urandom_range(0, 99);
      if (r < 45) k = SK_GOOD;
      else if (r < 60) k = SK_PADDED;
      else if (r < 72) k = SK_CUT_SHORT;
      else if (r < 82) k = SK_BAD_HEADER;
      else if (r < 92) k = SK_BAD_BACKREF;
      else k = SK_RUNT;
      if (k == SK_PADDED && $urandom_range(0, 4) == 0) n = 0;
      build_stream(k, n);
      send_stream();
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain, then watch a little longer for stray words.
    while (sb.decoded_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d compressed streams, %0d input words, %0d output words (%0d data)",
             streams, in_count, sb.words_seen, sb.data_words);
    $display("closing status seen: ok %0d, bad header %0d, bad back-reference %0d, early end %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_HEADER],
             sb.status_seen[ST_BAD_BACKREF], sb.status_seen[ST_TRUNCATED]);
    if (sb.mismatches == 0 && sb.decoded_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatched or unexpected words", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
